/* rtl/core/slcr_pkg.sv */
package slcr_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Scroll modes.
    localparam logic MODE_ENTRY = 1'b0;
    localparam logic MODE_EXIT  = 1'b1;

    // Input tdata layout, lowest bit first.
    localparam int IN_ADDR_LSB = 0;
    localparam int IN_DATA_LSB = 9;
    localparam int IN_MODE_BIT = 17;
    localparam int IN_OFFS_LSB = 18;
    localparam int IN_SCOL_LSB = 26;

    // Command queue between the front and the back.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Last LED of a 16-LED column.
    localparam logic [3:0] LAST_LED = 4'd15;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FG_COLOR,
        REG_BG_COLOR,
        REG_GRADIENT_ON,
        REG_MATERIAL_COLUMNS
    } cfg_reg_t;

    // Current configuration as seen by the front and the back.
    typedef struct packed {
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        logic        gradient_on;
        logic [8:0]  material_columns;
    } cfg_t;

    // One classified render command.
    typedef struct packed {
        logic        err;
        logic [3:0]  scol;
        logic [15:0] word;
    } cmd_t;

endpackage

/* rtl/core/slcr_ram.sv */
module slcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/slcr_front.sv */
module slcr_front #(
    parameter int SCREEN_COLUMNS = 16,
    parameter int MAX_COLUMNS    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           in_data,
    input  logic                  in_kind,
    input  slcr_pkg::cfg_t        cfg,
    input  logic [2:0]            q_count,
    output logic                  q_push,
    output slcr_pkg::cmd_t        q_cmd
);
    import slcr_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int MCW = $clog2(MAX_COLUMNS + 1);

    logic [8:0]     addr;
    logic [7:0]     data;
    logic           mode;
    logic [7:0]     offs;
    logic [3:0]     scol;
    logic           accept;
    logic           load_ok;
    logic [MCW-1:0] mlim;
    logic [7:0]     diff;
    logic [8:0]     bcol;
    logic           has_col;
    logic           err;
    logic [7:0]     even_byte;
    logic [7:0]     odd_byte;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic           s1_err_reg;
    logic           s1_has_reg;
    logic [3:0]     s1_scol_reg;

    // Field extraction from the input word.
    assign addr = in_data[IN_ADDR_LSB +: 9];
    assign data = in_data[IN_DATA_LSB +: 8];
    assign mode = in_data[IN_MODE_BIT];
    assign offs = in_data[IN_OFFS_LSB +: 8];
    assign scol = in_data[IN_SCOL_LSB +: 4];

    // Room is kept for the command still waiting on the store read.
    assign in_ready = ({1'b0, q_count} + {3'b000, s1_valid_reg}) < 4'(QDEPTH);
    assign accept   = in_valid && in_ready;

    // Loads beyond the store are dropped.
    assign load_ok = accept && (in_kind == REQ_LOAD) && (32'(addr[8:1]) < MAX_COLUMNS);

    // Classification of a render request.
    always_comb
    begin
        mlim = (32'(cfg.material_columns) > MAX_COLUMNS) ? MCW'(MAX_COLUMNS)
                                                         : MCW'(cfg.material_columns);
        diff = {4'b0000, scol} - offs;
        err  = (32'(scol) >= SCREEN_COLUMNS)
            || ((mode == MODE_ENTRY) && (32'(offs) > SCREEN_COLUMNS - 1))
            || ((mode == MODE_EXIT) && (32'(offs) > 32'(mlim)));
        if (mode == MODE_EXIT)
        begin
            bcol    = {1'b0, offs} + {5'b00000, scol};
            has_col = 32'(bcol) < 32'(mlim);
        end
        else
        begin
            bcol    = {1'b0, diff};
            has_col = ({4'b0000, scol} >= offs) && (32'(diff) < 32'(mlim));
        end
    end

    // Even and odd bytes of each column live in separate stores.
    slcr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_COLUMNS)
    ) u_even_ram (
        .clk   (clk),
        .we    (load_ok && !addr[0]),
        .waddr (CW'(addr[8:1])),
        .wdata (data),
        .re    (accept && (in_kind == REQ_RENDER)),
        .raddr (CW'(bcol)),
        .rdata (even_byte)
    );

    slcr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_COLUMNS)
    ) u_odd_ram (
        .clk   (clk),
        .we    (load_ok && addr[0]),
        .waddr (CW'(addr[8:1])),
        .wdata (data),
        .re    (accept && (in_kind == REQ_RENDER)),
        .raddr (CW'(bcol)),
        .rdata (odd_byte)
    );

    // Render commands wait in a register for the store data.
    assign s1_valid_next = accept && (in_kind == REQ_RENDER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_err_reg  <= err;
            s1_has_reg  <= has_col;
            s1_scol_reg <= scol;
        end
    end

    // Command into the queue; a missing column shows as an empty word.
    assign q_push     = s1_valid_reg;
    assign q_cmd.err  = s1_err_reg;
    assign q_cmd.scol = s1_scol_reg;
    assign q_cmd.word = s1_has_reg ? {odd_byte, even_byte} : 16'h0000;

endmodule

/* rtl/core/slcr_queue.sv */
module slcr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  slcr_pkg::cmd_t push_cmd,
    input  logic           pop,
    output slcr_pkg::cmd_t head_cmd,
    output logic [2:0]     count
);
    import slcr_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    // A word is never written into a full queue unless one is taken in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QDEPTH)) || pop)
        else $error("command queue overflow");

    // A word is never taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("command queue underflow");

endmodule

/* rtl/core/slcr_back.sv */
module slcr_back #(
    parameter int SCREEN_COLUMNS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  slcr_pkg::cfg_t cfg,
    input  slcr_pkg::cmd_t head_cmd,
    input  logic [2:0]     q_count,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [39:0]    out_data,
    output logic [1:0]     out_user,
    output logic           out_last
);
    import slcr_pkg::*;

    logic [7:0]  wheel_lut [256];
    logic        head_valid;
    logic        out_load;
    logic [3:0]  pos;
    logic        lit;
    logic [7:0]  led;

    logic [3:0]  k_reg;
    logic [3:0]  k_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  led_next;
    logic [23:0] color_next;
    logic [7:0]  wheel_next;
    logic        use_wheel_next;
    logic        err_next;
    logic        last_next;
    logic [7:0]  led_reg;
    logic [23:0] color_reg;
    logic [7:0]  wheel_reg;
    logic        use_wheel_reg;
    logic        err_reg;
    logic        last_reg;

    // Colour-wheel position for each chain index.
    for (genvar g = 0; g < 256; g++)
    begin : g_wheel
        assign wheel_lut[g] = 8'((g * 16) / SCREEN_COLUMNS);
    end

    // One LED result per cycle while a command waits and the output register can take it.
    assign head_valid = (q_count != 3'd0);
    assign out_load   = head_valid && (!valid_reg || out_ready);
    assign q_pop      = out_load && (head_cmd.err || (k_reg == LAST_LED));

    // Odd columns run reversed through the bitmap word.
    assign pos = head_cmd.scol[0] ? ~k_reg : k_reg;
    assign lit = head_cmd.word[pos];
    assign led = {head_cmd.scol, k_reg};

    // Result for the current LED.
    always_comb
    begin
        led_next       = led;
        color_next     = cfg.bg_color;
        wheel_next     = 8'h00;
        use_wheel_next = 1'b0;
        err_next       = 1'b0;
        last_next      = (k_reg == LAST_LED);
        if (head_cmd.err)
        begin
            led_next   = 8'h00;
            color_next = 24'h000000;
            err_next   = 1'b1;
            last_next  = 1'b1;
        end
        else if (lit && cfg.gradient_on)
        begin
            color_next     = 24'h000000;
            wheel_next     = wheel_lut[led];
            use_wheel_next = 1'b1;
        end
        else if (lit)
        begin
            color_next = cfg.fg_color;
        end
    end

    // LED counter and output valid.
    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        if (out_load)
        begin
            k_next     = q_pop ? 4'd0 : k_reg + 4'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            led_reg       <= led_next;
            color_reg     <= color_next;
            wheel_reg     <= wheel_next;
            use_wheel_reg <= use_wheel_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {wheel_reg, color_reg, led_reg};
    assign out_user  = {err_reg, use_wheel_reg};
    assign out_last  = last_reg;

    // An error result always closes its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> last_reg)
        else $error("error result without last");

    // A wheel result carries no RGB colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && use_wheel_reg) |-> (color_reg == 24'h000000) && !err_reg)
        else $error("wheel result with colour or error");

endmodule

/* rtl/core/serpentine_led_column_renderer.sv */
// Load words write the bitmap store at acceptance and give no result.
// A render word passes the store read register, the command queue and the output
// register, then gives one LED result per cycle while the output is taken: 16 results,
// or one for a range error. Later render words queue for the single output register.
// Reset clears control state and sets the configuration to its defaults;
// the bitmap store is not cleared and holds undefined data until loaded.
module serpentine_led_column_renderer #(
    parameter int SCREEN_COLUMNS = 16,
    parameter int MAX_COLUMNS    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_addr[8:0], byte_data[16:9], draw_mode[17], offset_column[25:18],
    // screen_column[29:26], zero fill[31:30]
    input  logic [31:0] s_axis_tdata,
    // req_type[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // led_index[7:0], color[31:8], wheel_pos[39:32]
    output logic [39:0] m_axis_tdata,
    // use_wheel[0], range_error[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import slcr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       q_push;
    logic       q_pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic [2:0] q_count;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FG_COLOR:         cfg_next.fg_color         = cfg_data;
                REG_BG_COLOR:         cfg_next.bg_color         = cfg_data;
                REG_GRADIENT_ON:      cfg_next.gradient_on      = cfg_data[0];
                REG_MATERIAL_COLUMNS: cfg_next.material_columns = cfg_data[8:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color         <= 24'hFFFFFF;
            cfg_reg.bg_color         <= 24'h000000;
            cfg_reg.gradient_on      <= 1'b0;
            cfg_reg.material_columns <= 9'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accepts, loads the store and classifies renders.
    slcr_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .MAX_COLUMNS    (MAX_COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_kind  (s_axis_tuser),
        .cfg      (cfg_reg),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Queue of classified render commands.
    slcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .count    (q_count)
    );

    // Back: emits the LED results.
    slcr_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_cmd  (head_cmd),
        .q_count   (q_count),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
